// File: design/swpd_pkg.sv
// Shared types and constants for the side-wall mode and PD steering block.
`timescale 1ns / 1ps
package swpd_pkg;

	localparam int DIST_W     = 18;
	localparam int GAIN_W     = 32;
	localparam int SPEED_W    = 14;
	localparam int HEAD_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int THR_W      = DIST_W + 1;
	localparam int ERR_W      = DIST_W + 2;
	localparam int DRIVE_W    = 16;
	localparam int MUL_A_W    = HEAD_W + 1;
	localparam int MUL_B_W    = 25;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int SD_W       = SPEED_W + HEAD_W + 1;
	localparam int SD_LO_W    = 24;
	localparam int SD_HI_W    = SD_W - SD_LO_W;
	localparam int FRAC_W     = 24;
	localparam int ACC_W      = 80;

	localparam logic [DIST_W-1:0]  TARGET_LEFT_RST  = 18'd20313;
	localparam logic [DIST_W-1:0]  TARGET_RIGHT_RST = 18'd20820;
	localparam logic [DRIVE_W-1:0] DRIVE_MAX        = 16'h7FFF;
	localparam logic [DRIVE_W-1:0] DRIVE_MIN        = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WALL_THRESHOLD      = 3'd0,
		CFG_THRESHOLD_REDUCTION = 3'd1,
		CFG_CHANGE_THRESHOLD    = 3'd2,
		CFG_TARGET_LEFT         = 3'd3,
		CFG_TARGET_RIGHT        = 3'd4,
		CFG_P_GAIN              = 3'd5,
		CFG_D_GAIN              = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_LEFT  = 2'd1,
		MODE_RIGHT = 2'd2,
		MODE_BOTH  = 2'd3
	} wall_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ERR,
		ST_DHI,
		ST_PERR,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

// File: design/swpd_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module swpd_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/swpd_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module swpd_mul
	import swpd_pkg::*;
(
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

	assign prod = prod_q;

endmodule

// File: design/side_wall_mode_and_pd_steer.sv
// Top level: side-wall mode selection and PD steering with ring-averaged change.
// A word accepted in ST_IDLE passes through ST_READ, ST_ERR, ST_DHI, ST_PERR and ST_ACC
// to ST_OUT, which loads the output register once it is free; the next word is taken back in ST_IDLE.
// The shared multiplier sets the pace: four products, each registered before use.
// Reset clears control state, the registers to their defaults and the ring valid
// bits at once; ring entries not yet written read as zero, so no clearing pass runs.
`timescale 1ns / 1ps
module side_wall_mode_and_pd_steer
	import swpd_pkg::*;
#(
	parameter int AVG_DEPTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [DIST_W-1:0]         left_distance,
	input  logic [DIST_W-1:0]         right_distance,
	input  logic signed [SPEED_W-1:0] move_speed,
	input  logic signed [HEAD_W-1:0]  heading_actual,
	input  logic signed [HEAD_W-1:0]  heading_ideal,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                wall_mode,
	output logic signed [DRIVE_W-1:0] drive_difference,
	output logic signed [THR_W-1:0]   left_threshold_used,
	output logic signed [THR_W-1:0]   right_threshold_used
);

	localparam int POS_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int SUM_W = DIST_W + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);
	localparam int RAM_W = 2 * DIST_W;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_DEPTH - 1);

	// configuration registers
	logic [DIST_W-1:0] wall_thr_q, thr_red_q, change_thr_q, target_l_q, target_r_q;
	logic [GAIN_W-1:0] p_gain_q, d_gain_q;

	// control state
	state_t            state_q, state_d;
	logic [POS_W-1:0]  pos_q;
	logic [AVG_DEPTH-1:0] ring_valid_q;
	logic              rd_valid_s1;
	logic [DIST_W-1:0] prev_l_q, prev_r_q;
	logic [SUM_W-1:0]  sum_l_q, sum_r_q;

	// item registers
	logic [DIST_W-1:0]         l_q, r_q, dl_q, dr_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [HEAD_W-1:0]  actual_q, ideal_q;
	logic signed [SD_HI_W-1:0] sd_hi_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [THR_W-1:0]   lth_q, rth_q;
	wall_mode_t                mode_q;
	logic signed [ACC_W-1:0]   acc_q;

	// output register
	logic                      out_valid_q;
	logic [1:0]                out_mode_q;
	logic signed [DRIVE_W-1:0] out_drive_q;
	logic signed [THR_W-1:0]   out_lth_q, out_rth_q;

	// datapath nets
	logic                      in_accept, out_free;
	logic [DIST_W-1:0]         dl, dr, old_l, old_r;
	logic [RAM_W-1:0]          ram_rdata;
	logic                      ram_re, ram_we;
	logic [SUM_W-1:0]          limit, sum_l_new, sum_r_new;
	logic                      over_l, over_r, lwall, rwall;
	logic signed [THR_W-1:0]   lth, rth;
	logic signed [THR_W:0]     l_cmp, r_cmp;
	logic signed [THR_W-1:0]   e_l, e_r;
	logic signed [ERR_W-1:0]   err;
	wall_mode_t                mode;
	logic signed [HEAD_W:0]    head_diff;
	mul_req_t                  mul_req;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   prod_ext;
	logic [ACC_W-FRAC_W-1:0]   shifted;
	logic                      in_range;
	logic [DRIVE_W-1:0]        drive_sat;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_thr_q   <= '0;
			thr_red_q    <= '0;
			change_thr_q <= '0;
			target_l_q   <= TARGET_LEFT_RST;
			target_r_q   <= TARGET_RIGHT_RST;
			p_gain_q     <= '0;
			d_gain_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WALL_THRESHOLD:      wall_thr_q   <= cfg_data[DIST_W-1:0];
				CFG_THRESHOLD_REDUCTION: thr_red_q    <= cfg_data[DIST_W-1:0];
				CFG_CHANGE_THRESHOLD:    change_thr_q <= cfg_data[DIST_W-1:0];
				CFG_TARGET_LEFT:         target_l_q   <= cfg_data[DIST_W-1:0];
				CFG_TARGET_RIGHT:        target_r_q   <= cfg_data[DIST_W-1:0];
				CFG_P_GAIN:              p_gain_q     <= cfg_data[GAIN_W-1:0];
				CFG_D_GAIN:              d_gain_q     <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// absolute change against the previous tick
	assign dl = (left_distance > prev_l_q) ? left_distance - prev_l_q
		: prev_l_q - left_distance;
	assign dr = (right_distance > prev_r_q) ? right_distance - prev_r_q
		: prev_r_q - right_distance;

	swpd_ram #(
		.WIDTH(RAM_W),
		.DEPTH(AVG_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata({dl_q, dr_q}),
		.re   (ram_re),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	// an entry never written reads as zero
	assign old_l = rd_valid_s1 ? ram_rdata[RAM_W-1:DIST_W] : '0;
	assign old_r = rd_valid_s1 ? ram_rdata[DIST_W-1:0] : '0;

	assign sum_l_new = sum_l_q - SUM_W'(old_l) + SUM_W'(dl_q);
	assign sum_r_new = sum_r_q - SUM_W'(old_r) + SUM_W'(dr_q);

	// threshold, mode and centring error
	assign limit  = SUM_W'(change_thr_q) * SUM_W'(AVG_DEPTH);
	assign over_l = sum_l_q > limit;
	assign over_r = sum_r_q > limit;
	assign lth    = $signed({1'b0, wall_thr_q}) - (over_l ? $signed({1'b0, thr_red_q})
		: THR_W'(0));
	assign rth    = $signed({1'b0, wall_thr_q}) - (over_r ? $signed({1'b0, thr_red_q})
		: THR_W'(0));
	assign l_cmp  = {lth[THR_W-1], lth} - $signed({2'b00, l_q});
	assign r_cmp  = {rth[THR_W-1], rth} - $signed({2'b00, r_q});
	assign lwall  = !l_cmp[THR_W] && (l_cmp != '0);
	assign rwall  = !r_cmp[THR_W] && (r_cmp != '0);
	assign e_l    = $signed({1'b0, target_l_q}) - $signed({1'b0, l_q});
	assign e_r    = $signed({1'b0, target_r_q}) - $signed({1'b0, r_q});

	always_comb begin
		mode = MODE_NONE;
		err  = '0;
		if (lwall && rwall) begin
			mode = MODE_BOTH;
			err  = ERR_W'(e_r) - ERR_W'(e_l);
		end else if (lwall) begin
			mode = MODE_LEFT;
			err  = -(ERR_W'(e_l) <<< 1);
		end else if (rwall) begin
			mode = MODE_RIGHT;
			err  = ERR_W'(e_r) <<< 1;
		end
	end

	assign head_diff = {actual_q[HEAD_W-1], actual_q} - {ideal_q[HEAD_W-1], ideal_q};

	swpd_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.prod(prod)
	);

	assign prod_ext = ACC_W'(prod);

	// shift by the fraction, then saturate
	assign shifted   = acc_q[ACC_W-1:FRAC_W];
	assign in_range  = (shifted[ACC_W-FRAC_W-1:DRIVE_W-1] == '0)
		|| (shifted[ACC_W-FRAC_W-1:DRIVE_W-1] == '1);
	assign drive_sat = in_range ? shifted[DRIVE_W-1:0]
		: (acc_q[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		mul_req   = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ram_re  = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_we    = 1'b1;
				mul_req.en = 1'b1;
				mul_req.a  = head_diff;
				mul_req.b  = MUL_B_W'(speed_q);
				state_d    = ST_ERR;
			end
			ST_ERR: begin
				// low part of speed * heading error, taken as unsigned
				mul_req.en = 1'b1;
				mul_req.a  = $signed({1'b0, d_gain_q});
				mul_req.b  = $signed(MUL_B_W'(prod[SD_LO_W-1:0]));
				state_d    = ST_DHI;
			end
			ST_DHI: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({1'b0, d_gain_q});
				mul_req.b  = MUL_B_W'(sd_hi_q);
				state_d    = ST_PERR;
			end
			ST_PERR: begin
				mul_req.en = 1'b1;
				mul_req.a  = $signed({1'b0, p_gain_q});
				mul_req.b  = MUL_B_W'(err_q);
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			ring_valid_q <= '0;
			rd_valid_s1  <= 1'b0;
			prev_l_q     <= '0;
			prev_r_q     <= '0;
			sum_l_q      <= '0;
			sum_r_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				rd_valid_s1 <= ring_valid_q[pos_q];
				prev_l_q    <= left_distance;
				prev_r_q    <= right_distance;
			end
			if (state_q == ST_READ) begin
				sum_l_q             <= sum_l_new;
				sum_r_q             <= sum_r_new;
				ring_valid_q[pos_q] <= 1'b1;
				pos_q               <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			l_q      <= left_distance;
			r_q      <= right_distance;
			dl_q     <= dl;
			dr_q     <= dr;
			speed_q  <= move_speed;
			actual_q <= heading_actual;
			ideal_q  <= heading_ideal;
		end
		case (state_q)
			ST_ERR: begin
				sd_hi_q <= prod[SD_W-1:SD_LO_W];
				lth_q   <= lth;
				rth_q   <= rth;
				mode_q  <= mode;
				err_q   <= err;
			end
			ST_DHI: begin
				acc_q <= -prod_ext;
			end
			ST_PERR: begin
				acc_q <= acc_q - (prod_ext <<< SD_LO_W);
			end
			ST_ACC: begin
				acc_q <= acc_q + prod_ext;
			end
			ST_OUT: begin
				if (out_free) begin
					out_mode_q  <= mode_q;
					out_drive_q <= drive_sat;
					out_lth_q   <= lth_q;
					out_rth_q   <= rth_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid            = out_valid_q;
	assign wall_mode            = out_mode_q;
	assign drive_difference     = out_drive_q;
	assign left_threshold_used  = out_lth_q;
	assign right_threshold_used = out_rth_q;

	// running sums never pass the ring's full-scale total
	a_sum_l_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_l_q <= SUM_W'(AVG_DEPTH) * SUM_W'({DIST_W{1'b1}}))
		else $error("left change sum out of range");

	a_sum_r_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_r_q <= SUM_W'(AVG_DEPTH) * SUM_W'({DIST_W{1'b1}}))
		else $error("right change sum out of range");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_READ && in_stall)
		else $error("accepted word did not start the read");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not loaded into the output register");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for side-wall mode selection and PD steering.
`timescale 1ns / 1ps
module tb
	import swpd_pkg::*;
;

	localparam int RING_DEPTH    = 8;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS   = 75;
	localparam int WALK_STEP     = 1500;
	localparam int DIST_TOP      = (1 << DIST_W) - 1;

	localparam logic [CFG_IDX_W-1:0]      CFG_UNUSED = 3'd7;
	localparam logic [DIST_W-1:0]         DIST_MAX   = '1;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 14'sh1FFF;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN  = 14'sh2000;
	localparam logic signed [HEAD_W-1:0]  HEAD_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [HEAD_W-1:0]  HEAD_MIN   = 32'sh8000_0000;

	typedef struct packed {
		logic [DIST_W-1:0]         left;
		logic [DIST_W-1:0]         right;
		logic signed [SPEED_W-1:0] speed;
		logic signed [HEAD_W-1:0]  actual;
		logic signed [HEAD_W-1:0]  ideal;
	} tick_t;

	typedef struct packed {
		wall_mode_t                mode;
		logic signed [DRIVE_W-1:0] drive;
		logic signed [THR_W-1:0]   lth;
		logic signed [THR_W-1:0]   rth;
	} steer_t;

	typedef logic [0:6][CFG_DATA_W-1:0] reg_set_t;

	typedef struct packed {
		logic [2:0] set_id;
		logic       typed_in;
		tick_t      word;
		steer_t     want;
	} dir_row_t;

	localparam logic [2:0] SET_RESET    = 3'd0;
	localparam logic [2:0] SET_SATURATE = 3'd1;
	localparam logic [2:0] SET_MODES    = 3'd2;
	localparam logic [2:0] SET_NEGATIVE = 3'd3;
	localparam logic [2:0] SET_AVERAGE  = 3'd4;
	localparam logic [2:0] SET_ALL_MAX  = 3'd5;
	localparam logic [2:0] SET_ALL_MIN  = 3'd6;

	// wall, reduction, change, target left, target right, p gain, d gain
	localparam reg_set_t REG_SETS [7] = '{
		'{32'd0, 32'd0, 32'd0, 32'd20313, 32'd20820, 32'd0, 32'd0},
		'{32'd262143, 32'd0, 32'd262143, 32'd20313, 32'd20820, 32'hFFFF_FFFF, 32'd0},
		'{32'd60000, 32'd80000, 32'd262143, 32'd40000, 32'd45000, 32'h0040_0000,
			32'h0000_1000},
		'{32'd60000, 32'd80000, 32'd0, 32'd40000, 32'd45000, 32'h0040_0000,
			32'h0000_1000},
		// junk above bit 17 of the wall threshold must be dropped
		'{32'hABC4_EA60, 32'd10000, 32'd1000, 32'd40000, 32'd45000, 32'h0100_0000,
			32'h0000_0800},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}
	};

	localparam steer_t STEER_IDLE = '{MODE_NONE, 16'sd0, 19'sd0, 19'sd0};
	localparam int     DIR_ROWS   = 24;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// defaults straight after reset: no wall, no gain
		'{SET_RESET, 1'b1, '{18'd0, 18'd0, 14'sd0, 32'sd0, 32'sd0}, STEER_IDLE},
		'{SET_RESET, 1'b1, '{DIST_MAX, DIST_MAX, SPEED_MAX, HEAD_MAX, HEAD_MIN}, STEER_IDLE},
		'{SET_RESET, 1'b1, '{18'd0, DIST_MAX, SPEED_MIN, HEAD_MIN, HEAD_MAX}, STEER_IDLE},
		'{SET_RESET, 1'b1, '{18'd12345, 18'd54321, -14'sd1, -32'sd1, 32'sd1}, STEER_IDLE},
		// full threshold, top gain: drive pinned at both rails, or zero with no error
		'{SET_SATURATE, 1'b1, '{18'd0, 18'd262142, 14'sd100, 32'sd0, 32'sd0},
			'{MODE_BOTH, DRIVE_MIN, 19'sd262143, 19'sd262143}},
		'{SET_SATURATE, 1'b1, '{18'd262142, 18'd0, 14'sd100, 32'sd0, 32'sd0},
			'{MODE_BOTH, DRIVE_MAX, 19'sd262143, 19'sd262143}},
		'{SET_SATURATE, 1'b1, '{DIST_MAX, DIST_MAX, SPEED_MIN, HEAD_MAX, HEAD_MIN},
			'{MODE_NONE, 16'sd0, 19'sd262143, 19'sd262143}},
		'{SET_SATURATE, 1'b1, '{18'd20313, 18'd20820, SPEED_MAX, HEAD_MIN, HEAD_MAX},
			'{MODE_BOTH, 16'sd0, 19'sd262143, 19'sd262143}},
		// every mode, and the threshold boundary
		'{SET_MODES, 1'b0, '{18'd30000, 18'd30000, 14'sd500, 32'sd1000000, 32'sd990000},
			STEER_IDLE},
		'{SET_MODES, 1'b0, '{18'd30000, 18'd100000, -14'sd700, 32'sd250000, 32'sd300000},
			STEER_IDLE},
		'{SET_MODES, 1'b0, '{18'd100000, 18'd30000, 14'sd1200, -32'sd40000, -32'sd20000},
			STEER_IDLE},
		'{SET_MODES, 1'b0, '{18'd100000, 18'd100000, SPEED_MIN, HEAD_MAX, HEAD_MIN},
			STEER_IDLE},
		'{SET_MODES, 1'b0, '{18'd59999, 18'd60000, 14'sd300, 32'sd5000, -32'sd5000},
			STEER_IDLE},
		// reduction larger than threshold: negative threshold, no wall
		'{SET_NEGATIVE, 1'b0, '{18'd30000, 18'd30000, 14'sd800, 32'sd0, 32'sd12000},
			STEER_IDLE},
		'{SET_NEGATIVE, 1'b0, '{18'd30000, 18'd30000, -14'sd800, 32'sd12000, 32'sd0},
			STEER_IDLE},
		// flush the ring with steady readings, then step right on the average limit
		'{SET_AVERAGE, 1'b0, '{18'd30000, 18'd30000, 14'sd400, 32'sd100, 32'sd0}, STEER_IDLE},
		'{SET_AVERAGE, 1'b0, '{18'd30000, 18'd30000, 14'sd400, 32'sd100, 32'sd0}, STEER_IDLE},
		'{SET_AVERAGE, 1'b0, '{18'd30000, 18'd30000, 14'sd400, 32'sd100, 32'sd0}, STEER_IDLE},
		'{SET_AVERAGE, 1'b0, '{18'd30000, 18'd30000, 14'sd400, 32'sd100, 32'sd0}, STEER_IDLE},
		'{SET_AVERAGE, 1'b0, '{18'd30000, 18'd30000, 14'sd400, 32'sd100, 32'sd0}, STEER_IDLE},
		'{SET_AVERAGE, 1'b0, '{18'd30000, 18'd30000, 14'sd400, 32'sd100, 32'sd0}, STEER_IDLE},
		'{SET_AVERAGE, 1'b0, '{18'd30000, 18'd30000, 14'sd400, 32'sd100, 32'sd0}, STEER_IDLE},
		'{SET_AVERAGE, 1'b0, '{18'd30000, 18'd30000, 14'sd400, 32'sd100, 32'sd0}, STEER_IDLE},
		'{SET_AVERAGE, 1'b0, '{18'd38000, 18'd38001, 14'sd400, 32'sd20000, 32'sd0}, STEER_IDLE}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [DIST_W-1:0]         left_distance = '0;
	logic [DIST_W-1:0]         right_distance = '0;
	logic signed [SPEED_W-1:0] move_speed = '0;
	logic signed [HEAD_W-1:0]  heading_actual = '0;
	logic signed [HEAD_W-1:0]  heading_ideal = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [1:0]                wall_mode;
	logic signed [DRIVE_W-1:0] drive_difference;
	logic signed [THR_W-1:0]   left_threshold_used;
	logic signed [THR_W-1:0]   right_threshold_used;

	side_wall_mode_and_pd_steer #(.AVG_DEPTH(RING_DEPTH)) DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state and its copy of the registers
	logic [DIST_W-1:0] wall_thr, thr_cut, change_thr, tgt_left, tgt_right;
	logic [GAIN_W-1:0] p_gain, d_gain;
	logic [DIST_W-1:0] left_ring [RING_DEPTH];
	logic [DIST_W-1:0] right_ring [RING_DEPTH];
	logic [DIST_W+2:0] left_sum, right_sum;
	logic [DIST_W-1:0] last_left, last_right;
	int                ring_pos;

	steer_t steer_q [$];
	int     mismatches = 0;
	int     cycle_count = 0;
	int     idle_pct = 0;
	int     stall_pct = 0;
	int     walk_left = 20000;
	int     walk_right = 20000;

	function automatic void clear_predictor();
		wall_thr = '0;
		thr_cut = '0;
		change_thr = '0;
		tgt_left = TARGET_LEFT_RST;
		tgt_right = TARGET_RIGHT_RST;
		p_gain = '0;
		d_gain = '0;
		for (int k = 0; k < RING_DEPTH; k++) begin
			left_ring[k] = '0;
			right_ring[k] = '0;
		end
		left_sum = '0;
		right_sum = '0;
		last_left = '0;
		last_right = '0;
		ring_pos = 0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_WALL_THRESHOLD:      wall_thr = data[DIST_W-1:0];
			CFG_THRESHOLD_REDUCTION: thr_cut = data[DIST_W-1:0];
			CFG_CHANGE_THRESHOLD:    change_thr = data[DIST_W-1:0];
			CFG_TARGET_LEFT:         tgt_left = data[DIST_W-1:0];
			CFG_TARGET_RIGHT:        tgt_right = data[DIST_W-1:0];
			CFG_P_GAIN:              p_gain = data;
			CFG_D_GAIN:              d_gain = data;
			default: ;
		endcase
	endfunction

	function automatic logic [DIST_W-1:0] abs_change(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic steer_t predict_steer(tick_t w);
		logic [DIST_W-1:0] dl, dr;
		longint            lth, rth, err, l_um, r_um, tl, tr, limit;
		logic signed [95:0] err_x, speed_x, diff_x, total;
		steer_t            s;
		dl = abs_change(w.left, last_left);
		dr = abs_change(w.right, last_right);
		left_sum = left_sum - left_ring[ring_pos] + dl;
		right_sum = right_sum - right_ring[ring_pos] + dr;
		left_ring[ring_pos] = dl;
		right_ring[ring_pos] = dr;
		ring_pos = (ring_pos + 1) % RING_DEPTH;
		last_left = w.left;
		last_right = w.right;

		// average above limit, compared without dividing
		limit = change_thr;
		limit = limit * RING_DEPTH;
		lth = wall_thr;
		rth = wall_thr;
		if (left_sum > limit)
			lth = lth - thr_cut;
		if (right_sum > limit)
			rth = rth - thr_cut;

		l_um = w.left;
		r_um = w.right;
		tl = tgt_left;
		tr = tgt_right;
		if (lth > l_um && rth > r_um) begin
			s.mode = MODE_BOTH;
			err = (tr - r_um) - (tl - l_um);
		end else if (lth > l_um) begin
			s.mode = MODE_LEFT;
			err = -2 * (tl - l_um);
		end else if (rth > r_um) begin
			s.mode = MODE_RIGHT;
			err = 2 * (tr - r_um);
		end else begin
			s.mode = MODE_NONE;
			err = 0;
		end

		err_x = err;
		speed_x = $signed(w.speed);
		diff_x = $signed(w.actual) - $signed(w.ideal);
		total = $signed({64'd0, p_gain}) * err_x - $signed({64'd0, d_gain}) * speed_x * diff_x;
		total = total >>> FRAC_W;
		if (total > 96'sd32767)
			s.drive = DRIVE_MAX;
		else if (total < -96'sd32768)
			s.drive = DRIVE_MIN;
		else
			s.drive = total[DRIVE_W-1:0];
		s.lth = lth[THR_W-1:0];
		s.rth = rth[THR_W-1:0];
		return s;
	endfunction

	// mostly a slow drift, now and then a jump near the threshold or anywhere
	function automatic int wander(int cur);
		int v;
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			v = cur + int'($urandom_range(2 * WALK_STEP)) - WALK_STEP;
		else if (pick < 85)
			v = $urandom_range(2 * int'(wall_thr) + 2000);
		else if (pick < 95)
			v = $urandom_range(DIST_TOP);
		else
			v = ($urandom_range(1) != 0) ? DIST_TOP : 0;
		if (v < 0)
			v = 0;
		if (v > DIST_TOP)
			v = DIST_TOP;
		return v;
	endfunction

	function automatic tick_t next_tick();
		tick_t w;
		int    sp;
		walk_left = wander(walk_left);
		walk_right = wander(walk_right);
		w.left = walk_left[DIST_W-1:0];
		w.right = walk_right[DIST_W-1:0];
		case ($urandom_range(9))
			0: begin
				sp = $urandom();
				w.speed = sp[SPEED_W-1:0];
			end
			1: w.speed = ($urandom_range(1) != 0) ? SPEED_MAX : SPEED_MIN;
			default: begin
				sp = int'($urandom_range(4000)) - 2000;
				w.speed = sp[SPEED_W-1:0];
			end
		endcase
		w.actual = $urandom();
		if ($urandom_range(4) == 0)
			w.ideal = $urandom();
		else
			w.ideal = w.actual + int'($urandom_range(40000)) - 20000;
		return w;
	endfunction

	// random junk above the register width
	function automatic logic [CFG_DATA_W-1:0] with_junk(int v);
		return ($urandom() << DIST_W) | v;
	endfunction

	function automatic reg_set_t random_setting();
		reg_set_t s;
		s[CFG_WALL_THRESHOLD] = with_junk($urandom_range(90000, 5000));
		s[CFG_THRESHOLD_REDUCTION] = with_junk($urandom_range(40000));
		s[CFG_CHANGE_THRESHOLD] = with_junk($urandom_range(6000));
		s[CFG_TARGET_LEFT] = with_junk($urandom_range(60000, 5000));
		s[CFG_TARGET_RIGHT] = with_junk($urandom_range(60000, 5000));
		s[CFG_P_GAIN] = $urandom_range(1 << FRAC_W);
		s[CFG_D_GAIN] = $urandom_range(8000);
		return s;
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic load_setting(input reg_set_t s);
		for (int i = 0; i < 7; i++)
			cfg_write(i[CFG_IDX_W-1:0], s[i]);
		// a write past the register list must change nothing
		cfg_write(CFG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
	endtask

	task automatic await_idle();
		in_valid <= 1'b0;
		while (steer_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic send_word(input tick_t w, input logic typed_in, input steer_t want);
		steer_t guess;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		left_distance <= w.left;
		right_distance <= w.right;
		move_speed <= w.speed;
		heading_actual <= w.actual;
		heading_ideal <= w.ideal;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		guess = predict_steer(w);
		steer_q.push_back(typed_in ? want : guess);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : check_results
		steer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (steer_q.size() == 0) begin
				$display("%0t: result with nothing expected, mode %0d drive %0d", $time,
					wall_mode, drive_difference);
				mismatches++;
			end else begin
				want = steer_q.pop_front();
				if (wall_mode !== want.mode) begin
					$display("%0t: wall_mode expected %0d, got %0d", $time, want.mode, wall_mode);
					mismatches++;
				end
				if (drive_difference !== want.drive) begin
					$display("%0t: drive_difference expected %0d, got %0d", $time,
						$signed(want.drive), drive_difference);
					mismatches++;
				end
				if (left_threshold_used !== want.lth) begin
					$display("%0t: left_threshold_used expected %0d, got %0d", $time,
						$signed(want.lth), left_threshold_used);
					mismatches++;
				end
				if (right_threshold_used !== want.rth) begin
					$display("%0t: right_threshold_used expected %0d, got %0d", $time,
						$signed(want.rth), right_threshold_used);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int cur_set;
		clear_predictor();
		cur_set = SET_RESET;
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TABLE[i].set_id != cur_set) begin
				await_idle();
				cur_set = DIR_TABLE[i].set_id;
				load_setting(REG_SETS[cur_set]);
			end
			send_word(DIR_TABLE[i].word, DIR_TABLE[i].typed_in, DIR_TABLE[i].want);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			await_idle();
			if (ph == 2)
				load_setting(REG_SETS[SET_ALL_MAX]);
			else if (ph == 6)
				load_setting(REG_SETS[SET_ALL_MIN]);
			else
				load_setting(random_setting());
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 76;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 76;
				end
				default: begin
					idle_pct = 22;
					stall_pct = 22;
				end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// hold the sender until the pipeline has fully drained
				if (ph == 4 && n == PHASE_WORDS / 2)
					await_idle();
				send_word(next_tick(), 1'b0, STEER_IDLE);
			end
		end

		in_valid <= 1'b0;
		while (steer_q.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
